>>> src/cda_pkg.sv
package cda_pkg;

  // Year range and the last day number (31 December of the last year).
  localparam logic [11:0] FIRST_YEAR  = 12'd1970;
  localparam logic [11:0] LAST_YEAR   = 12'd2099;
  localparam logic [15:0] LAST_DAYNUM = 16'd47481;

  // Operation codes.
  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_SUB  = 2'd1;
  localparam logic [1:0] OP_DIFF = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD1  = 2'd1;
  localparam logic [1:0] ST_BAD2  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       conv_init;
    logic       conv_sel;
    logic       conv_step;
    logic       keep_n1;
    logic       back_init;
    logic       yback_step;
    logic       mback_step;
    logic       res_date;
    logic       res_diff;
    logic       res_err;
    logic [1:0] err_code;
    logic       out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       valid1;
    logic       valid2;
    logic       conv_done;
    logic       range_ok;
    logic       yback_done;
    logic       mback_done;
  } sts_t;

  // Leap year test. Within 1970..2099 the only century year is 2000, which
  // is divisible by 400 and therefore leap, so the divisible-by-4 test is
  // exact over the whole range.
  function automatic logic is_leap(logic [11:0] y);
    return y[1:0] == 2'b00;
  endfunction

  function automatic logic [8:0] year_len(logic [11:0] y);
    return is_leap(y) ? 9'd366 : 9'd365;
  endfunction

  function automatic logic [4:0] days_in_month(logic [3:0] m, logic [11:0] y);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2: len = is_leap(y) ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in the year before the first of month m.
  function automatic logic [8:0] days_before_month(logic [3:0] m, logic [11:0] y);
    logic [8:0] base;
    case (m)
      4'd1:    base = 9'd0;
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (m > 4'd2 && is_leap(y)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

  function automatic logic date_ok(logic [4:0] d, logic [3:0] m, logic [11:0] y);
    return (y >= FIRST_YEAR) && (y <= LAST_YEAR) && (m >= 4'd1) && (m <= 4'd12) &&
           (d >= 5'd1) && (d <= days_in_month(m, y));
  endfunction

endpackage

>>> src/cda_if.sv
// Request channel: one operation with its two dates and day count.
interface cda_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [4:0]  day;
  logic [3:0]  month;
  logic [11:0] year;
  logic [4:0]  other_day;
  logic [3:0]  other_month;
  logic [11:0] other_year;
  logic [15:0] count;

  modport source (
    output valid, op, day, month, year, other_day, other_month, other_year, count,
    input  ready
  );
  modport sink (
    input  valid, op, day, month, year, other_day, other_month, other_year, count,
    output ready
  );
endinterface

// Response channel: resulting date, day difference and status.
interface cda_out_if;
  logic               valid;
  logic               ready;
  logic [4:0]         result_day;
  logic [3:0]         result_month;
  logic [11:0]        result_year;
  logic signed [16:0] difference;
  logic [1:0]         status;

  modport source (
    output valid, result_day, result_month, result_year, difference, status,
    input  ready
  );
  modport sink (
    input  valid, result_day, result_month, result_year, difference, status,
    output ready
  );
endinterface

>>> src/cda_dp.sv
module cda_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cda_pkg::cmd_t      cmd_i,
  input  logic [1:0]         op_i,
  input  logic [4:0]         day_i,
  input  logic [3:0]         month_i,
  input  logic [11:0]        year_i,
  input  logic [4:0]         other_day_i,
  input  logic [3:0]         other_month_i,
  input  logic [11:0]        other_year_i,
  input  logic [15:0]        count_i,
  output cda_pkg::sts_t      sts_o,
  output logic [4:0]         result_day_o,
  output logic [3:0]         result_month_o,
  output logic [11:0]        result_year_o,
  output logic signed [16:0] difference_o,
  output logic [1:0]         status_o
);

  // Latched request.
  logic [1:0]  op_q;
  logic [4:0]  d1_q, d2_q;
  logic [3:0]  m1_q, m2_q;
  logic [11:0] y1_q, y2_q;
  logic [15:0] cnt_q;

  // Walker: day number accumulator, current year and month, target year.
  logic [15:0] acc_q;
  logic [11:0] wy_q;
  logic [3:0]  wm_q;
  logic [11:0] tgt_q;
  logic [15:0] n1_q;

  // Staged result and output registers.
  logic [4:0]         res_day_q, out_day_q;
  logic [3:0]         res_month_q, out_month_q;
  logic [11:0]        res_year_q, out_year_q;
  logic signed [16:0] res_diff_q, out_diff_q;
  logic [1:0]         res_st_q, out_st_q;

  logic [4:0]  dsel;
  logic [3:0]  msel;
  logic [11:0] ysel;
  logic [8:0]  doy;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic [16:0] sum;
  logic        is_add;

  // Day of year of the selected date, counted from zero.
  always_comb begin
    dsel = cmd_i.conv_sel ? d2_q : d1_q;
    msel = cmd_i.conv_sel ? m2_q : m1_q;
    ysel = cmd_i.conv_sel ? y2_q : y1_q;
    doy  = cda_pkg::days_before_month(msel, ysel) + {4'd0, dsel} - 9'd1;
  end

  assign ylen   = cda_pkg::year_len(wy_q);
  assign mlen   = cda_pkg::days_in_month(wm_q, wy_q);
  assign sum    = {1'b0, acc_q} + {1'b0, cnt_q};
  assign is_add = (op_q == cda_pkg::OP_ADD);

  // Status back to the controller.
  always_comb begin
    sts_o.op         = op_q;
    sts_o.valid1     = cda_pkg::date_ok(d1_q, m1_q, y1_q);
    sts_o.valid2     = cda_pkg::date_ok(d2_q, m2_q, y2_q);
    sts_o.conv_done  = (wy_q == tgt_q);
    sts_o.range_ok   = is_add ? (sum <= {1'b0, cda_pkg::LAST_DAYNUM}) : (cnt_q <= acc_q);
    sts_o.yback_done = (acc_q < {7'd0, ylen}) || (wy_q >= cda_pkg::LAST_YEAR);
    sts_o.mback_done = (acc_q < {11'd0, mlen}) || (wm_q >= 4'd12);
  end

  // Request latch and the year/month walker.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      d1_q  <= day_i;
      m1_q  <= month_i;
      y1_q  <= year_i;
      d2_q  <= other_day_i;
      m2_q  <= other_month_i;
      y2_q  <= other_year_i;
      cnt_q <= count_i;
    end
    if (cmd_i.keep_n1) begin
      n1_q <= acc_q;
    end
    if (cmd_i.conv_init) begin
      acc_q <= {7'd0, doy};
      wy_q  <= cda_pkg::FIRST_YEAR;
      tgt_q <= ysel;
    end else if (cmd_i.conv_step) begin
      acc_q <= acc_q + {7'd0, ylen};
      wy_q  <= wy_q + 12'd1;
    end else if (cmd_i.back_init) begin
      acc_q <= is_add ? sum[15:0] : (acc_q - cnt_q);
      wy_q  <= cda_pkg::FIRST_YEAR;
      wm_q  <= 4'd1;
    end else if (cmd_i.yback_step) begin
      acc_q <= acc_q - {7'd0, ylen};
      wy_q  <= wy_q + 12'd1;
    end else if (cmd_i.mback_step) begin
      acc_q <= acc_q - {11'd0, mlen};
      wm_q  <= wm_q + 4'd1;
    end
  end

  // Result staging and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_day_q   <= '0;
      res_month_q <= '0;
      res_year_q  <= '0;
      res_diff_q  <= '0;
      res_st_q    <= cda_pkg::ST_OK;
      out_day_q   <= '0;
      out_month_q <= '0;
      out_year_q  <= '0;
      out_diff_q  <= '0;
      out_st_q    <= cda_pkg::ST_OK;
    end else begin
      if (cmd_i.res_date) begin
        res_day_q   <= acc_q[4:0] + 5'd1;
        res_month_q <= wm_q;
        res_year_q  <= wy_q;
        res_diff_q  <= '0;
        res_st_q    <= cda_pkg::ST_OK;
      end else if (cmd_i.res_diff) begin
        res_day_q   <= '0;
        res_month_q <= '0;
        res_year_q  <= '0;
        res_diff_q  <= $signed({1'b0, n1_q} - {1'b0, acc_q});
        res_st_q    <= cda_pkg::ST_OK;
      end else if (cmd_i.res_err) begin
        res_day_q   <= '0;
        res_month_q <= '0;
        res_year_q  <= '0;
        res_diff_q  <= '0;
        res_st_q    <= cmd_i.err_code;
      end
      if (cmd_i.out_load) begin
        out_day_q   <= res_day_q;
        out_month_q <= res_month_q;
        out_year_q  <= res_year_q;
        out_diff_q  <= res_diff_q;
        out_st_q    <= res_st_q;
      end
    end
  end

  assign result_day_o   = out_day_q;
  assign result_month_o = out_month_q;
  assign result_year_o  = out_year_q;
  assign difference_o   = out_diff_q;
  assign status_o       = out_st_q;

`ifndef SYNTH
  // The forward walk never passes the year of the date being converted.
  a_conv_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.conv_step |-> wy_q < tgt_q)
    else $error("forward year walk ran past its target year");

  // The backward year walk stops at the last year of the range.
  a_yback_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.yback_step |-> wy_q < cda_pkg::LAST_YEAR)
    else $error("backward year walk left the year range");

  // A finished month walk leaves a day offset that fits in a month.
  a_day_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_date |-> acc_q < 16'd31)
    else $error("day offset out of range at end of month walk");
`endif

endmodule

>>> src/cda_ctrl.sv
module cda_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  cda_pkg::sts_t sts_i,
  output cda_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_CONV1 = 3'd2;
  localparam logic [2:0] S_CONV2 = 3'd3;
  localparam logic [2:0] S_YBACK = 3'd4;
  localparam logic [2:0] S_MBACK = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_vld_q, out_vld_d;
  logic       slot_free;

  assign slot_free = !out_vld_q || out_ready_i;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.op == cda_pkg::OP_NONE) begin
          cmd_o.res_err  = 1'b1;
          cmd_o.err_code = cda_pkg::ST_OK;
          state_d        = S_DONE;
        end else if (!sts_i.valid1) begin
          cmd_o.res_err  = 1'b1;
          cmd_o.err_code = cda_pkg::ST_BAD1;
          state_d        = S_DONE;
        end else if (sts_i.op == cda_pkg::OP_DIFF && !sts_i.valid2) begin
          cmd_o.res_err  = 1'b1;
          cmd_o.err_code = cda_pkg::ST_BAD2;
          state_d        = S_DONE;
        end else begin
          cmd_o.conv_init = 1'b1;
          state_d         = S_CONV1;
        end
      end
      S_CONV1: begin
        if (!sts_i.conv_done) begin
          cmd_o.conv_step = 1'b1;
        end else if (sts_i.op == cda_pkg::OP_DIFF) begin
          cmd_o.keep_n1   = 1'b1;
          cmd_o.conv_init = 1'b1;
          cmd_o.conv_sel  = 1'b1;
          state_d         = S_CONV2;
        end else if (!sts_i.range_ok) begin
          cmd_o.res_err  = 1'b1;
          cmd_o.err_code = cda_pkg::ST_RANGE;
          state_d        = S_DONE;
        end else begin
          cmd_o.back_init = 1'b1;
          state_d         = S_YBACK;
        end
      end
      S_CONV2: begin
        if (!sts_i.conv_done) begin
          cmd_o.conv_step = 1'b1;
        end else begin
          cmd_o.res_diff = 1'b1;
          state_d        = S_DONE;
        end
      end
      S_YBACK: begin
        if (!sts_i.yback_done) begin
          cmd_o.yback_step = 1'b1;
        end else begin
          state_d = S_MBACK;
        end
      end
      S_MBACK: begin
        if (!sts_i.mback_done) begin
          cmd_o.mback_step = 1'b1;
        end else begin
          cmd_o.res_date = 1'b1;
          state_d        = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid: set on a load, cleared when the response is taken.
  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.out_load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_vld_q;

`ifndef SYNTH
  // A response only appears after the controller has finished an item.
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q) == S_DONE)
    else $error("response valid raised outside the done state");
`endif

endmodule

>>> src/calendar_date_arithmetic.sv
// Gregorian date arithmetic over 1970-01-01 .. 2099-12-31.
// Request channel req_i carries op, the first date, the second date and a
// day count; response channel rsp_o carries the resulting date, the signed
// day difference and a status code. Both use valid/ready; a request is
// taken on a clock edge with valid and ready high.
// One request is handled at a time. A date is turned into a day number by
// stepping one year per cycle from 1970, and a day number back into a date
// by stepping one year per cycle and then one month per cycle; that walk
// sets the latency. An invalid date or op 3 is answered straight after the
// check, an add or subtract that leaves the range after converting the
// first date, an add or subtract after converting the first date and
// walking back to the result year and then the result month, and a
// difference after converting both dates.
// The next request is taken in the cycle after the response is loaded.
// The response sits in an output register; if the receiver stalls, the
// next finished response waits in the datapath and the request channel
// stays not ready until the output register is free.
// Reset clears the controller, the output valid and the response fields.
module calendar_date_arithmetic (
  input logic      clk_i,
  input logic      rst_ni,
  cda_in_if.sink   req_i,
  cda_out_if.source rsp_o
);

  cda_pkg::cmd_t cmd;
  cda_pkg::sts_t sts;

  // Sequencer.
  cda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Date walker and result registers.
  cda_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .op_i           (req_i.op),
    .day_i          (req_i.day),
    .month_i        (req_i.month),
    .year_i         (req_i.year),
    .other_day_i    (req_i.other_day),
    .other_month_i  (req_i.other_month),
    .other_year_i   (req_i.other_year),
    .count_i        (req_i.count),
    .sts_o          (sts),
    .result_day_o   (rsp_o.result_day),
    .result_month_o (rsp_o.result_month),
    .result_year_o  (rsp_o.result_year),
    .difference_o   (rsp_o.difference),
    .status_o       (rsp_o.status)
  );

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;

  // One request as the sender offers it.
  typedef struct {
    logic [1:0]  op;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [4:0]  other_day;
    logic [3:0]  other_month;
    logic [11:0] other_year;
    logic [15:0] count;
  } date_req_t;

  // One response as the block should return it.
  typedef struct {
    logic [4:0]         day;
    logic [3:0]         month;
    logic [11:0]        year;
    logic signed [16:0] difference;
    logic [1:0]         status;
  } date_result_t;

  logic clk;
  logic rst_n;

  cda_in_if  req_if ();
  cda_out_if rsp_if ();

  calendar_date_arithmetic u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  date_result_t expected_results[$];
  int           errors        = 0;
  int           tx_max_gap    = 18;
  int           rx_max_stall  = 18;
  int           rx_hold_cycles = 0;

  always #5 clk = ~clk;

  // Run limit, far above the slowest legal run.
  initial begin
    #15000000;
    $display("[calendar_date_arithmetic] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Calendar predictor.
  // ---------------------------------------------------------------------

  function automatic bit leap_year(int y);
    if (y % 400 == 0) begin
      return 1'b1;
    end
    if (y % 100 == 0) begin
      return 1'b0;
    end
    return (y % 4) == 0;
  endfunction

  function automatic int month_days(int m, int y);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11: return 30;
      2: return leap_year(y) ? 29 : 28;
      default: return 0;
    endcase
  endfunction

  function automatic bit calendar_date_ok(int d, int m, int y);
    if (y < int'(cda_pkg::FIRST_YEAR) || y > int'(cda_pkg::LAST_YEAR)) begin
      return 1'b0;
    end
    if (m < 1 || m > 12) begin
      return 1'b0;
    end
    return d >= 1 && d <= month_days(m, y);
  endfunction

  // Days since 1 January of the first year.
  function automatic int day_serial(int d, int m, int y);
    int n;
    n = 0;
    for (int k = int'(cda_pkg::FIRST_YEAR); k < y; k++) begin
      n += leap_year(k) ? 366 : 365;
    end
    for (int k = 1; k < m; k++) begin
      n += month_days(k, y);
    end
    return n + d - 1;
  endfunction

  function automatic void serial_to_date(input int serial, output int d, output int m,
                                         output int y);
    int rest;
    rest = serial;
    y = int'(cda_pkg::FIRST_YEAR);
    while (rest >= (leap_year(y) ? 366 : 365)) begin
      rest -= leap_year(y) ? 366 : 365;
      y++;
    end
    m = 1;
    while (rest >= month_days(m, y)) begin
      rest -= month_days(m, y);
      m++;
    end
    d = rest + 1;
  endfunction

  function automatic date_result_t predict_result(date_req_t r);
    date_result_t res;
    int n1, n2, d, m, y;
    res = '{default: '0};
    if (r.op == cda_pkg::OP_NONE) begin
      return res;
    end
    if (!calendar_date_ok(r.day, r.month, r.year)) begin
      res.status = cda_pkg::ST_BAD1;
    end else if (r.op == cda_pkg::OP_DIFF) begin
      if (!calendar_date_ok(r.other_day, r.other_month, r.other_year)) begin
        res.status = cda_pkg::ST_BAD2;
      end else begin
        n1 = day_serial(r.day, r.month, r.year);
        n2 = day_serial(r.other_day, r.other_month, r.other_year);
        res.difference = 17'(n1 - n2);
      end
    end else begin
      n1 = day_serial(r.day, r.month, r.year);
      n1 = (r.op == cda_pkg::OP_ADD) ? n1 + int'(r.count) : n1 - int'(r.count);
      if (n1 < 0 || n1 > int'(cda_pkg::LAST_DAYNUM)) begin
        res.status = cda_pkg::ST_RANGE;
      end else begin
        serial_to_date(n1, d, m, y);
        res.day   = 5'(d);
        res.month = 4'(m);
        res.year  = 12'(y);
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Request side.
  // ---------------------------------------------------------------------

  function automatic date_req_t make_req(logic [1:0] op, int d, int m, int y, int od,
                                         int om, int oy, int cnt);
    date_req_t r;
    r.op          = op;
    r.day         = 5'(d);
    r.month       = 4'(m);
    r.year        = 12'(y);
    r.other_day   = 5'(od);
    r.other_month = 4'(om);
    r.other_year  = 12'(oy);
    r.count       = 16'(cnt);
    return r;
  endfunction

  // Offer one request; called and left at a falling edge. Valid stays high
  // afterwards so that back-to-back requests need no gap.
  task automatic send_request(date_req_t r);
    int gap;
    gap = (tx_max_gap == 0) ? 0 : $urandom_range(0, tx_max_gap);
    if (gap != 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.op          = r.op;
    req_if.day         = r.day;
    req_if.month       = r.month;
    req_if.year        = r.year;
    req_if.other_day   = r.other_day;
    req_if.other_month = r.other_month;
    req_if.other_year  = r.other_year;
    req_if.count       = r.count;
    req_if.valid       = 1'b1;
    do begin
      @(posedge clk);
    end while (!req_if.ready);
    expected_results.push_back(predict_result(r));
    @(negedge clk);
  endtask

  // Stop offering and wait until every response is back.
  task automatic wait_drained();
    req_if.valid = 1'b0;
    while (expected_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (10) @(negedge clk);
  endtask

  // A valid date, often at a month end; now and then one day past it.
  function automatic void pick_calendar_date(output int d, output int m, output int y);
    y = $urandom_range(int'(cda_pkg::FIRST_YEAR), int'(cda_pkg::LAST_YEAR));
    m = $urandom_range(1, 12);
    case ($urandom_range(0, 19))
      0, 1, 2, 3: d = month_days(m, y);
      4: d = month_days(m, y) + 1;
      default: d = $urandom_range(1, month_days(m, y));
    endcase
  endfunction

  function automatic int pick_count();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 31);
      1: return $urandom_range(0, 1000);
      2: return $urandom_range(0, int'(cda_pkg::LAST_DAYNUM));
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic date_req_t pick_raw_request();
    date_req_t r;
    r.op          = 2'($urandom);
    r.day         = 5'($urandom);
    r.month       = 4'($urandom);
    r.year        = 12'($urandom);
    r.other_day   = 5'($urandom);
    r.other_month = 4'($urandom);
    r.other_year  = 12'($urandom);
    r.count       = 16'($urandom);
    return r;
  endfunction

  // Mostly well-formed requests, with some raw noise mixed in.
  function automatic date_req_t pick_request();
    int d, m, y, od, om, oy;
    logic [1:0] op;
    if ($urandom_range(0, 9) == 0) begin
      return pick_raw_request();
    end
    pick_calendar_date(d, m, y);
    pick_calendar_date(od, om, oy);
    case ($urandom_range(0, 2))
      0: op = cda_pkg::OP_ADD;
      1: op = cda_pkg::OP_SUB;
      default: op = cda_pkg::OP_DIFF;
    endcase
    return make_req(op, d, m, y, od, om, oy, pick_count());
  endfunction

  // ---------------------------------------------------------------------
  // Response side.
  // ---------------------------------------------------------------------

  // Receiver: random stall before each response, or a long hold on request.
  initial begin
    int stall;
    rsp_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (rx_hold_cycles != 0) begin
        rsp_if.ready = 1'b0;
        repeat (rx_hold_cycles) @(negedge clk);
        rx_hold_cycles = 0;
      end
      stall = (rx_max_stall == 0) ? 0 : $urandom_range(0, rx_max_stall);
      if (stall != 0) begin
        rsp_if.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_if.ready = 1'b1;
      do begin
        @(posedge clk);
      end while (!(rsp_if.valid && rsp_if.ready) && rx_hold_cycles == 0);
      @(negedge clk);
    end
  end

  // Compare each accepted response with the oldest expectation.
  always @(posedge clk) begin
    date_result_t want;
    if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: response with no request pending, actual status %0d", $time,
                 rsp_if.status);
      end else begin
        want = expected_results.pop_front();
        if (want.day !== rsp_if.result_day) begin
          errors++;
          $display("%0t: result_day expected %0d actual %0d", $time, want.day,
                   rsp_if.result_day);
        end
        if (want.month !== rsp_if.result_month) begin
          errors++;
          $display("%0t: result_month expected %0d actual %0d", $time, want.month,
                   rsp_if.result_month);
        end
        if (want.year !== rsp_if.result_year) begin
          errors++;
          $display("%0t: result_year expected %0d actual %0d", $time, want.year,
                   rsp_if.result_year);
        end
        if (want.difference !== rsp_if.difference) begin
          errors++;
          $display("%0t: difference expected %0d actual %0d", $time, want.difference,
                   rsp_if.difference);
        end
        if (want.status !== rsp_if.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   rsp_if.status);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------

  // Range ends, leap days, every status and the unused op.
  task automatic test_directed();
    send_request(make_req(cda_pkg::OP_ADD, 1, 1, 1970, 0, 0, 0, 0));
    send_request(make_req(cda_pkg::OP_SUB, 31, 12, 2099, 0, 0, 0, 0));
    send_request(make_req(cda_pkg::OP_ADD, 1, 1, 1970, 0, 0, 0, 47481));
    send_request(make_req(cda_pkg::OP_ADD, 1, 1, 1970, 0, 0, 0, 47482));
    send_request(make_req(cda_pkg::OP_SUB, 1, 1, 1970, 0, 0, 0, 1));
    send_request(make_req(cda_pkg::OP_ADD, 31, 12, 2099, 0, 0, 0, 1));
    send_request(make_req(cda_pkg::OP_SUB, 31, 12, 2099, 0, 0, 0, 65535));
    send_request(make_req(cda_pkg::OP_ADD, 15, 6, 2030, 0, 0, 0, 65535));
    send_request(make_req(cda_pkg::OP_ADD, 28, 2, 2000, 0, 0, 0, 1));
    send_request(make_req(cda_pkg::OP_ADD, 31, 12, 1999, 0, 0, 0, 1));
    send_request(make_req(cda_pkg::OP_SUB, 1, 3, 2000, 0, 0, 0, 1));
    send_request(make_req(cda_pkg::OP_SUB, 1, 3, 2001, 0, 0, 0, 1));
    send_request(make_req(cda_pkg::OP_DIFF, 31, 12, 2099, 1, 1, 1970, 0));
    send_request(make_req(cda_pkg::OP_DIFF, 1, 1, 1970, 31, 12, 2099, 0));
    send_request(make_req(cda_pkg::OP_DIFF, 29, 2, 2096, 29, 2, 2096, 0));
    // Invalid first date: bad day, bad month, year outside the range.
    send_request(make_req(cda_pkg::OP_ADD, 0, 5, 2000, 0, 0, 0, 3));
    send_request(make_req(cda_pkg::OP_SUB, 31, 4, 2001, 0, 0, 0, 3));
    send_request(make_req(cda_pkg::OP_DIFF, 29, 2, 1971, 1, 1, 1980, 0));
    send_request(make_req(cda_pkg::OP_ADD, 30, 2, 2000, 0, 0, 0, 3));
    send_request(make_req(cda_pkg::OP_ADD, 1, 0, 1990, 0, 0, 0, 3));
    send_request(make_req(cda_pkg::OP_SUB, 1, 13, 1990, 0, 0, 0, 3));
    send_request(make_req(cda_pkg::OP_ADD, 31, 15, 4095, 31, 15, 4095, 65535));
    send_request(make_req(cda_pkg::OP_ADD, 31, 12, 1969, 0, 0, 0, 1));
    send_request(make_req(cda_pkg::OP_SUB, 1, 1, 2100, 0, 0, 0, 1));
    // Invalid second date with a valid first one.
    send_request(make_req(cda_pkg::OP_DIFF, 1, 1, 2000, 31, 15, 4095, 0));
    send_request(make_req(cda_pkg::OP_DIFF, 10, 10, 2010, 29, 2, 2099, 0));
    // The unused op answers with all fields zero.
    send_request(make_req(cda_pkg::OP_NONE, 31, 15, 4095, 31, 15, 4095, 65535));
    send_request(make_req(cda_pkg::OP_NONE, 1, 1, 2000, 1, 1, 2000, 5));
  endtask

  task automatic test_random_dates(int n);
    for (int i = 0; i < n; i++) begin
      send_request(pick_request());
    end
  endtask

  // Receiver holds off long enough that the block fills and stalls requests.
  task automatic test_output_stall();
    tx_max_gap     = 0;
    rx_hold_cycles = 1500;
    for (int i = 0; i < 20; i++) begin
      send_request(pick_request());
    end
    tx_max_gap = 18;
  endtask

  // No idling on either side.
  task automatic test_back_to_back(int n);
    tx_max_gap   = 0;
    rx_max_stall = 0;
    for (int i = 0; i < n; i++) begin
      send_request(pick_request());
    end
    tx_max_gap   = 18;
    rx_max_stall = 18;
  endtask

  task automatic test_raw_fields(int n);
    for (int i = 0; i < n; i++) begin
      send_request(pick_raw_request());
    end
  endtask

  // Main sequence.
  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    req_if.valid       = 1'b0;
    req_if.op          = cda_pkg::OP_ADD;
    req_if.day         = '0;
    req_if.month       = '0;
    req_if.year        = '0;
    req_if.other_day   = '0;
    req_if.other_month = '0;
    req_if.other_year  = '0;
    req_if.count       = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    wait_drained();
    test_random_dates(500);
    wait_drained();
    test_output_stall();
    wait_drained();
    test_back_to_back(150);
    wait_drained();
    test_raw_fields(150);
    wait_drained();

    repeat (300) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("[calendar_date_arithmetic] OK");
    end else begin
      $display("[calendar_date_arithmetic] ERROR");
    end
    $finish;
  end

endmodule
